[rtl/core/ldc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Log record deframer package
// Shared types, codes and the byte-wide CRC-32 update used by the deframer.
// ----------------------------------------------------------------------------
package ldc_pkg;

  // Command codes as they arrive on the input stream.
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Reflected CRC-32 polynomial and register seed.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_RESTART
  } op_e;

  // Kind of a result transfer.
  typedef enum logic [2:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_COMMIT,
    KIND_REJECT,
    KIND_CLEAN,
    KIND_TRUNC
  } kind_e;

  // One queued operation.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Fold one byte into a reflected CRC-32 register, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ldc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts input transfers, classifies the command and holds the resulting
// operations in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ldc_front import ldc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] data_i,
  output q_head_t         head_o,
  input  wire logic       pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        keep;
  logic        push;
  item_t       new_item;

  // Classify the command; the unused code is taken and dropped.
  always_comb begin
    keep          = 1'b1;
    new_item.data = data_i;
    new_item.op   = OP_BYTE;
    unique case (cmd_i)
      CMD_BYTE:    new_item.op = OP_BYTE;
      CMD_END:     new_item.op = OP_END;
      CMD_RESTART: new_item.op = OP_RESTART;
      default:     keep = 1'b0;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // The count never goes past the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("ldc_front: queue count overflow");

  // The back end only takes an entry that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_o.valid)
    else $error("ldc_front: pop from empty queue");

  // A full queue with no pop stays full in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd2 && !pop_i) |=> cnt_q == 2'd2)
    else $error("ldc_front: full queue lost an entry");

endmodule
`default_nettype wire

[rtl/core/ldc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer back end
// Walks the record layout, updates the CRC, counts key and value bytes and
// loads each result into the output register.
// ----------------------------------------------------------------------------
module ldc_back import ldc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire q_head_t    head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      out_kind_o,
  output logic [7:0]      out_byte_o
);

  typedef enum logic [2:0] {
    PH_KEYLEN,
    PH_VALLEN,
    PH_KEY,
    PH_VALUE,
    PH_CHECK,
    PH_HALTED
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [1:0]             pos_q, pos_d;
  logic [LENGTH_BITS-1:0] key_len_q, key_len_d;
  logic [LENGTH_BITS-1:0] val_len_q, val_len_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            crc_q, crc_d;
  logic [23:0]            check_q, check_d;
  logic                   out_valid_q, out_valid_d;
  kind_e                  kind_q, kind_d;
  logic [7:0]             byte_q, byte_d;

  logic                   can_go;
  logic                   emit;
  logic [63:0]            wide;
  logic [LENGTH_BITS-1:0] len_part;
  logic                   len_hi;
  logic                   ovf_new;
  logic [LENGTH_BITS-1:0] key_new;
  logic [LENGTH_BITS-1:0] val_new;
  logic [31:0]            crc_upd;
  logic [31:0]            check_full;

  // Take the queue head whenever the output register is free or draining.
  assign can_go = !out_valid_q || out_ready_i;
  assign pop_o  = head_i.valid && can_go;

  // Place of the incoming byte within a little-endian length field.
  always_comb begin
    wide       = 64'(head_i.item.data) << {pos_q, 3'b000};
    len_part   = wide[LENGTH_BITS-1:0];
    len_hi     = |(wide >> LENGTH_BITS);
    ovf_new    = ((pos_q == 2'd0) ? 1'b0 : ovf_q) | len_hi;
    key_new    = ((pos_q == 2'd0) ? '0 : key_len_q) | len_part;
    val_new    = ((pos_q == 2'd0) ? '0 : val_len_q) | len_part;
    crc_upd    = crc32_byte(crc_q, head_i.item.data);
    check_full = {head_i.item.data, check_q};
  end

  // Record walk.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    key_len_d = key_len_q;
    val_len_d = val_len_q;
    left_d    = left_q;
    ovf_d     = ovf_q;
    crc_d     = crc_q;
    check_d   = check_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    byte_d    = byte_q;

    if (pop_o) begin
      unique case (head_i.item.op)
        OP_RESTART: begin
          phase_d   = PH_KEYLEN;
          pos_d     = 2'd0;
          key_len_d = '0;
          val_len_d = '0;
          left_d    = '0;
          ovf_d     = 1'b0;
          crc_d     = CRC_INIT;
          check_d   = '0;
        end
        OP_END: begin
          if (phase_q != PH_HALTED) begin
            phase_d = PH_HALTED;
            emit    = 1'b1;
            byte_d  = 8'd0;
            kind_d  = (pos_q == 2'd0 && (phase_q == PH_KEYLEN || phase_q == PH_VALLEN))
                      ? KIND_CLEAN : KIND_TRUNC;
          end
        end
        default: begin
          unique case (phase_q)
            PH_KEYLEN: begin
              crc_d     = crc_upd;
              key_len_d = key_new;
              ovf_d     = ovf_new;
              pos_d     = pos_q + 2'd1;
              if (pos_q == 2'd3) begin
                if (ovf_new) begin
                  phase_d = PH_HALTED;
                  emit    = 1'b1;
                  kind_d  = KIND_TRUNC;
                  byte_d  = 8'd0;
                end else begin
                  phase_d = PH_VALLEN;
                end
              end
            end
            PH_VALLEN: begin
              crc_d     = crc_upd;
              val_len_d = val_new;
              ovf_d     = ovf_new;
              pos_d     = pos_q + 2'd1;
              if (pos_q == 2'd3) begin
                if (ovf_new) begin
                  phase_d = PH_HALTED;
                  emit    = 1'b1;
                  kind_d  = KIND_TRUNC;
                  byte_d  = 8'd0;
                end else if (key_len_q != '0) begin
                  phase_d = PH_KEY;
                  left_d  = key_len_q;
                end else if (val_new != '0) begin
                  phase_d = PH_VALUE;
                  left_d  = val_new;
                end else begin
                  phase_d = PH_CHECK;
                  left_d  = '0;
                end
              end
            end
            PH_KEY: begin
              crc_d  = crc_upd;
              left_d = left_q - LENGTH_BITS'(1);
              emit   = 1'b1;
              kind_d = KIND_KEY;
              byte_d = head_i.item.data;
              if (left_q == LENGTH_BITS'(1)) begin
                if (val_len_q != '0) begin
                  phase_d = PH_VALUE;
                  left_d  = val_len_q;
                end else begin
                  phase_d = PH_CHECK;
                end
              end
            end
            PH_VALUE: begin
              crc_d  = crc_upd;
              left_d = left_q - LENGTH_BITS'(1);
              emit   = 1'b1;
              kind_d = KIND_VALUE;
              byte_d = head_i.item.data;
              if (left_q == LENGTH_BITS'(1)) begin
                phase_d = PH_CHECK;
              end
            end
            PH_CHECK: begin
              pos_d = pos_q + 2'd1;
              unique case (pos_q)
                2'd0:    check_d = {16'd0, head_i.item.data};
                2'd1:    check_d[15:8] = head_i.item.data;
                2'd2:    check_d[23:16] = head_i.item.data;
                default: begin
                  emit   = 1'b1;
                  byte_d = 8'd0;
                  if (~crc_q == check_full) begin
                    phase_d = PH_KEYLEN;
                    crc_d   = CRC_INIT;
                    kind_d  = KIND_COMMIT;
                  end else begin
                    phase_d = PH_HALTED;
                    kind_d  = KIND_REJECT;
                  end
                end
              endcase
            end
            default: begin
              // Halted: bytes are dropped until a restart.
            end
          endcase
        end
      endcase
    end

    // Output register: load a new result or drain the current one.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KEYLEN;
      pos_q       <= 2'd0;
      key_len_q   <= '0;
      val_len_q   <= '0;
      left_q      <= '0;
      ovf_q       <= 1'b0;
      crc_q       <= CRC_INIT;
      check_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_KEY;
      byte_q      <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      key_len_q   <= key_len_d;
      val_len_q   <= val_len_d;
      left_q      <= left_d;
      ovf_q       <= ovf_d;
      crc_q       <= crc_d;
      check_q     <= check_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      byte_q      <= byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;

  // Key and value phases always have bytes still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_KEY || phase_q == PH_VALUE) |-> left_q != '0)
    else $error("ldc_back: body phase with no bytes left");

  // A halted deframer produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_HALTED) |-> !emit)
    else $error("ldc_back: result while halted");

  // A restart brings back the seed and the first header phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop_o && head_i.item.op == OP_RESTART)
                   |=> (crc_q == CRC_INIT && phase_q == PH_KEYLEN && !ovf_q))
    else $error("ldc_back: restart did not clear state");

  // Only key and value results carry a data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && kind_q != KIND_KEY && kind_q != KIND_VALUE)
                   |-> byte_q == 8'd0)
    else $error("ldc_back: status result with nonzero byte");

endmodule
`default_nettype wire

[rtl/core/log_record_deframer_crc32_check_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Log record deframer with CRC-32 check
// Splits a byte stream of length-prefixed key/value records and checks the
// CRC-32 trailer of each record.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one log byte per transfer in tdata, with the
//   command in tuser: log byte, end of log, or restart from the start of log.
//   The m_axis channel returns key and value bytes as they arrive, then one
//   commit or reject per record at its last check byte, and a clean or a
//   truncated end at end of log. Each transfer yields zero or one result.
//   Throughput is one transfer per cycle while the receiver keeps up, set by
//   the byte-wide CRC-32 update and the length down-counter, both computed
//   combinationally in the back end. An accepted input transfer is first
//   written into the queue and its result then into the output register. A
//   two-entry queue separates input from the record walk and keeps taking
//   input while a result waits, until the queue is full.
//   Reset empties the queue and output register and puts the walk at the
//   key length field with the CRC seeded. While the receiver stalls the
//   output register holds; the queue fills and then tready drops.
//   After a reject, truncation or clean end only a restart resumes.
// ----------------------------------------------------------------------------
module log_record_deframer_crc32_check_unit import ldc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] command
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser_o    // [2:0] kind
);

  q_head_t head;
  logic    pop;

  ldc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .data_i     (s_axis_tdata_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  ldc_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_byte_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

[verif/log_record_deframer_crc32_check_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Log record deframer testbench
// Drives length-prefixed key/value records with CRC-32 trailers into the
// deframer and checks every result transfer against a predictor of the walk.
// A short directed table covers clean ends, truncation, halting, restart and
// a committed record. Random records follow, mostly well formed with random
// content, mixed with corrupted checks, huge lengths, cut records and noise.
// Both stream sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module log_record_deframer_crc32_check_unit_tb;
  import ldc_pkg::*;

  localparam int unsigned LEN_BITS    = 32;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int          PHASE_ITEMS = 375;

  // The fourth command code has no name in the package; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Position of the record walk.
  typedef enum logic [2:0] {
    ST_KEYLEN,
    ST_VALLEN,
    ST_KEY,
    ST_VALUE,
    ST_CHECK,
    ST_HALTED
  } walk_e;

  // One result transfer.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } deframe_res_t;

  // One row of the directed table.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       fill_check;
    logic       typed;
    logic       has_res;
    kind_e      kind;
    logic [7:0] res_data;
  } dir_row_t;

  localparam int DIR_COUNT = 27;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // End of log right after reset is a clean end.
    '{CMD_END,     8'h00, 1'b0, 1'b1, 1'b1, KIND_CLEAN,  8'h00},
    // Halted: bytes, ends and the unused command give nothing.
    '{CMD_BYTE,    8'hAA, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_END,     8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_UNUSED,  8'hFF, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_RESTART, 8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    // Record with a one-byte key and a one-byte value.
    '{CMD_BYTE,    8'h01, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h01, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'hFF, 1'b0, 1'b1, 1'b1, KIND_KEY,    8'hFF},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b1, KIND_VALUE,  8'h00},
    // Correct check bytes, filled in from the predicted CRC.
    '{CMD_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b1, 1'b1, 1'b1, KIND_COMMIT, 8'h00},
    // Key length only, then end of log at record offset four.
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_END,     8'h00, 1'b0, 1'b1, 1'b1, KIND_CLEAN,  8'h00},
    // End of log inside a length field is a truncation.
    '{CMD_RESTART, 8'h00, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_BYTE,    8'h80, 1'b0, 1'b1, 1'b0, KIND_KEY,    8'h00},
    '{CMD_END,     8'h00, 1'b0, 1'b1, 1'b1, KIND_TRUNC,  8'h00}
  };

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;  // [7:0] data_byte
  logic [1:0] s_axis_tuser_i  = 2'd0;   // [1:0] command
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic [2:0] m_axis_tuser_o;           // [2:0] kind

  // Predictor state of the record walk.
  walk_e       w_phase;
  logic [1:0]  w_pos;
  logic [31:0] w_key_len;
  logic [31:0] w_val_len;
  logic [31:0] w_left;
  logic [31:0] w_crc;
  logic [31:0] w_check;

  deframe_res_t expected_results [$];
  int           mismatches    = 0;
  int           items_done    = 0;
  int           stall_cycles  = 0;
  int           src_idle_pct  = 0;
  int           sink_stall_pct = 0;

  log_record_deframer_crc32_check_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // Reflected CRC-32 update, one bit per pass with a masked polynomial.
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'h0, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    return r;
  endfunction

  function automatic bit length_overflows(input logic [31:0] len);
    return (LEN_BITS < 32) && ((len >> LEN_BITS) != 32'h0);
  endfunction

  task automatic clear_walk();
    w_phase   = ST_KEYLEN;
    w_pos     = 2'd0;
    w_key_len = 32'h0;
    w_val_len = 32'h0;
    w_left    = 32'h0;
    w_crc     = CRC_INIT;
    w_check   = 32'h0;
  endtask

  // Advance the predicted walk by one input transfer.
  task automatic deframe_step(input logic [1:0] cmd, input logic [7:0] b,
                              output bit produced, output deframe_res_t res);
    logic [31:0] field;
    produced = 1'b0;
    res      = '{KIND_KEY, 8'h00};
    if (cmd == CMD_RESTART) begin
      clear_walk();
      return;
    end
    if (cmd == CMD_UNUSED || w_phase == ST_HALTED) return;
    if (cmd == CMD_END) begin
      produced = 1'b1;
      res.kind = (w_pos == 2'd0 && (w_phase == ST_KEYLEN || w_phase == ST_VALLEN)) ?
                 KIND_CLEAN : KIND_TRUNC;
      w_phase  = ST_HALTED;
      return;
    end
    case (w_phase)
      ST_KEYLEN, ST_VALLEN: begin
        w_crc = crc_fold(w_crc, b);
        field = (w_phase == ST_KEYLEN) ? w_key_len : w_val_len;
        if (w_pos == 2'd0) field = 32'h0;
        field[{w_pos, 3'b000} +: 8] = b;
        if (w_phase == ST_KEYLEN) w_key_len = field;
        else w_val_len = field;
        if (w_pos != 2'd3) begin
          w_pos++;
        end else begin
          w_pos = 2'd0;
          if (length_overflows(field)) begin
            w_phase  = ST_HALTED;
            produced = 1'b1;
            res.kind = KIND_TRUNC;
          end else if (w_phase == ST_KEYLEN) begin
            w_phase = ST_VALLEN;
          end else if (w_key_len != 32'h0) begin
            w_phase = ST_KEY;
            w_left  = w_key_len;
          end else if (w_val_len != 32'h0) begin
            w_phase = ST_VALUE;
            w_left  = w_val_len;
          end else begin
            w_phase = ST_CHECK;
            w_left  = 32'h0;
          end
        end
      end
      ST_KEY: begin
        w_crc = crc_fold(w_crc, b);
        w_left--;
        if (w_left == 32'h0) begin
          if (w_val_len != 32'h0) begin
            w_phase = ST_VALUE;
            w_left  = w_val_len;
          end else begin
            w_phase = ST_CHECK;
          end
        end
        produced = 1'b1;
        res      = '{KIND_KEY, b};
      end
      ST_VALUE: begin
        w_crc = crc_fold(w_crc, b);
        w_left--;
        if (w_left == 32'h0) w_phase = ST_CHECK;
        produced = 1'b1;
        res      = '{KIND_VALUE, b};
      end
      default: begin
        if (w_pos == 2'd0) w_check = 32'h0;
        w_check[{w_pos, 3'b000} +: 8] = b;
        if (w_pos != 2'd3) begin
          w_pos++;
        end else begin
          w_pos    = 2'd0;
          produced = 1'b1;
          if (~w_crc == w_check) begin
            w_phase  = ST_KEYLEN;
            w_crc    = CRC_INIT;
            res.kind = KIND_COMMIT;
          end else begin
            w_phase  = ST_HALTED;
            res.kind = KIND_REJECT;
          end
        end
      end
    endcase
  endtask

  // Offer one input transfer, wait for it to be taken and record what it causes.
  // Called just after a rising edge; returns just after the accepting edge.
  task automatic apply(input logic [1:0] cmd, input logic [7:0] data,
                       input bit typed = 1'b0, input bit t_has = 1'b0,
                       input deframe_res_t t_res = '0);
    bit           ok;
    bit           got;
    deframe_res_t res;
    if (cmd != CMD_UNUSED && (w_phase != ST_HALTED || cmd == CMD_RESTART)) items_done++;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= cmd;
    // Handshake signals are stable at the falling edge before the accepting edge.
    do begin
      @(negedge clk_i);
      ok = s_axis_tready_o;
      @(posedge clk_i);
    end while (!ok);
    deframe_step(cmd, data, got, res);
    if (typed) begin
      got = t_has;
      res = t_res;
    end
    if (got) expected_results.push_back(res);
  endtask

  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 32'h0;
    if (r < 8) return 32'($urandom_range(8, 1));
    return 32'($urandom_range(40, 9));
  endfunction

  // One record: mostly well formed, sometimes corrupted, cut short or oversized.
  task automatic send_record();
    logic [7:0]  rec [$];
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [31:0] crc;
    bit          huge;
    int          cut;
    huge = ($urandom_range(99) < 4);
    klen = huge ? $urandom() : pick_len();
    vlen = huge ? $urandom() : pick_len();
    for (int i = 0; i < 4; i++) rec.push_back(klen[8*i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(vlen[8*i +: 8]);
    if (huge) begin
      repeat ($urandom_range(12)) rec.push_back(8'($urandom()));
      cut = $urandom_range(rec.size(), 2);
    end else begin
      repeat (klen + vlen) rec.push_back(8'($urandom()));
      crc = CRC_INIT;
      foreach (rec[i]) crc = crc_fold(crc, rec[i]);
      crc = ~crc;
      // A flipped check bit makes the record fail its check.
      if ($urandom_range(99) < 12) crc[$urandom_range(31)] ^= 1'b1;
      for (int i = 0; i < 4; i++) rec.push_back(crc[8*i +: 8]);
      cut = -1;
      if ($urandom_range(99) < 10) cut = $urandom_range(1) ? 4 : $urandom_range(rec.size() - 1);
    end
    foreach (rec[i]) begin
      if (i == cut) break;
      if ($urandom_range(99) < 2) apply(CMD_UNUSED, 8'($urandom()));
      apply(CMD_BYTE, rec[i]);
    end
    if (cut >= 0) apply($urandom_range(1) ? CMD_END : CMD_RESTART, 8'($urandom()));
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(negedge clk_i) begin
    deframe_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, out_byte 0x%02h", m_axis_tuser_o, m_axis_tdata_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o != want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o != want.data) begin
          $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data,
                 m_axis_tdata_o);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which neither side transfers anything.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] data;
    dir_row_t   row;
    int         r;
    clear_walk();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < DIR_COUNT; i++) begin
      row  = DIR_ROWS[i];
      data = row.fill_check ? 8'((~w_crc) >> {w_pos, 3'b000}) : row.data;
      apply(row.cmd, data, row.typed, row.has_res, '{row.kind, row.res_data});
    end

    // Random records over four idling phases.
    items_done = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      while (items_done < (ph + 1) * PHASE_ITEMS) begin
        if (w_phase == ST_HALTED) begin
          // Ignored traffic while halted, then a restart.
          repeat ($urandom_range(2)) begin
            r = $urandom_range(2);
            apply(r == 0 ? CMD_BYTE : (r == 1 ? CMD_END : CMD_UNUSED), 8'($urandom()));
          end
          apply(CMD_RESTART, 8'($urandom()));
        end else if (w_phase != ST_KEYLEN || w_pos != 2'd0) begin
          // Realign after a record that left the walk mid-record.
          apply(CMD_RESTART, 8'($urandom()));
        end else if ($urandom_range(19) == 0) begin
          apply(CMD_END, 8'($urandom()));
        end else begin
          send_record();
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
